### src/gprt_pkg.sv
// Shared types and constants for the grid permutation remap table.
// Used by gprt_table, gprt_cdiv and grid_permutation_remap_table.
`default_nettype none

package gprt_pkg;

    localparam int TYPE_W   = 2;
    localparam int IDX_W    = 13;
    localparam int CELL_W   = 23;
    localparam int ROWO_W   = 11;
    localparam int COLO_W   = 13;
    localparam int KIND_W   = 2;
    // widest table address / entry over the whole parameter range
    localparam int TBL_W    = 16;

    typedef enum logic [TYPE_W-1:0] {
        REQ_SWAP_ROW = 2'd0,
        REQ_SWAP_COL = 2'd1,
        REQ_QUERY    = 2'd2,
        REQ_LOCATE   = 2'd3
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE = 2'd0,
        KIND_POS   = 2'd1,
        KIND_ERR   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWAP_RD,
        ST_SWAP_WR1,
        ST_SWAP_WR2,
        ST_QRY_RD,
        ST_QRY_MUL,
        ST_QRY_SUM,
        ST_LOC_DIV,
        ST_LOC_RD,
        ST_LOC_GET,
        ST_RESULT
    } state_t;

    // one axis: forward table with two read ports, inverse with one
    typedef struct packed {
        logic             rd_en;
        logic [TBL_W-1:0] rd_a;
        logic [TBL_W-1:0] rd_b;
        logic [TBL_W-1:0] rd_inv;
        logic             fwd_we;
        logic [TBL_W-1:0] fwd_waddr;
        logic [TBL_W-1:0] fwd_wdata;
        logic             inv_we;
        logic [TBL_W-1:0] inv_waddr;
        logic [TBL_W-1:0] inv_wdata;
    } tbl_cmd_t;

    typedef struct packed {
        logic [TBL_W-1:0] fwd_qa;
        logic [TBL_W-1:0] fwd_qb;
        logic [TBL_W-1:0] inv_q;
    } tbl_rsp_t;

endpackage

`default_nettype wire

### src/gprt_table.sv
// Forward and inverse permutation memories for one axis of the grid.
// Depends on gprt_pkg for the command and response structs.
`default_nettype none

module gprt_table
    import gprt_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic     aclk,
    input  wire tbl_cmd_t cmd,
    output tbl_rsp_t      rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AW-1:0] fwd_mem [DEPTH];
    logic [AW-1:0] inv_mem [DEPTH];

    logic [AW-1:0] qa_reg;
    logic [AW-1:0] qb_reg;
    logic [AW-1:0] qi_reg;

    always_ff @(posedge aclk) begin
        if (cmd.fwd_we) begin
            fwd_mem[cmd.fwd_waddr[AW-1:0]] <= cmd.fwd_wdata[AW-1:0];
        end
        if (cmd.rd_en) begin
            qa_reg <= fwd_mem[cmd.rd_a[AW-1:0]];
            qb_reg <= fwd_mem[cmd.rd_b[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.inv_we) begin
            inv_mem[cmd.inv_waddr[AW-1:0]] <= cmd.inv_wdata[AW-1:0];
        end
        if (cmd.rd_en) begin
            qi_reg <= inv_mem[cmd.rd_inv[AW-1:0]];
        end
    end

    assign rsp.fwd_qa = TBL_W'(qa_reg);
    assign rsp.fwd_qb = TBL_W'(qb_reg);
    assign rsp.inv_q  = TBL_W'(qi_reg);

endmodule

`default_nettype wire

### src/gprt_cdiv.sv
// Splits a 0-based cell number into row and column by the constant COLS.
// Reciprocal multiply, remainder, one correction step. Uses gprt_pkg.
`default_nettype none

module gprt_cdiv
    import gprt_pkg::*;
#(
    parameter int COLS = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [CELL_W-1:0] in_num,
    output logic                   out_valid,
    output logic [CELL_W-1:0]      out_quo,
    output logic [TBL_W:0]         out_rem
);

    localparam int NW = CELL_W;
    localparam int CW = TBL_W + 1;          // holds COLS itself
    localparam int RW = CW + 1;             // estimate remainder < 2*COLS
    localparam longint unsigned RECIP = (64'd1 << NW) / COLS;
    localparam logic [NW-1:0] RECIP_L = NW'(RECIP);
    localparam logic [CW-1:0] COLS_L  = CW'(COLS);

    logic            v1_reg, v2_reg;
    logic [2*NW-1:0] prod_reg, prod_next;
    logic [NW-1:0]   n1_reg;
    logic [NW-1:0]   q2_reg, q_est;
    logic [RW-1:0]   r2_reg, r_next;
    logic [NW+CW-1:0] qc, r_full;
    logic            fix;

    // estimate is the true quotient or one below it
    assign prod_next = {{NW{1'b0}}, in_num} * {{NW{1'b0}}, RECIP_L};
    assign q_est     = prod_reg[2*NW-1:NW];
    assign qc        = {{CW{1'b0}}, q_est} * {{NW{1'b0}}, COLS_L};
    assign r_full    = {{CW{1'b0}}, n1_reg} - qc;
    assign r_next    = r_full[RW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        n1_reg   <= in_num;
        q2_reg   <= q_est;
        r2_reg   <= r_next;
    end

    assign fix       = r2_reg >= {1'b0, COLS_L};
    assign out_valid = v2_reg;
    assign out_quo   = fix ? (q2_reg + NW'(1)) : q2_reg;
    assign out_rem   = fix ? CW'(r2_reg - {1'b0, COLS_L}) : CW'(r2_reg);

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> ({1'b0, out_rem} < {1'b0, COLS_L}))
        else $error("cdiv: corrected remainder not below COLS");

    a_est_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (r2_reg < {COLS_L, 1'b0}))
        else $error("cdiv: quotient estimate off by more than one");

    a_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |=> v2_reg)
        else $error("cdiv: valid lost in pipeline");

endmodule

`default_nettype wire

### src/grid_permutation_remap_table.sv
// Top level: request FSM, range checks, result register.
// Uses gprt_pkg, gprt_table (one per axis) and gprt_cdiv.
//
//  channel | dir | handshake          | word
//  s_      | in  | s_valid / s_ready  | req_type, first_index, second_index, cell_number
//  m_      | out | m_valid / m_ready  | value_out, row_out, col_out, result_kind
//
// Steps per request: a swap reads, then writes twice (set by the one write port
// of each table); a query reads, multiplies and sums; a locate divides, reads
// and gets; a range error goes straight to ST_RESULT. After reset a clearing
// pass writes the identity into all tables; s_ready stays low until it ends.
// s_ready is high while idle, even while a result still waits on m_ready; a
// new result waits in ST_RESULT until the output register is free.
`default_nettype none

module grid_permutation_remap_table
    import gprt_pkg::*;
#(
    parameter int ROWS = 1024,
    parameter int COLS = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [TYPE_W-1:0] s_req_type,
    input  wire logic [IDX_W-1:0]  s_first_index,
    input  wire logic [IDX_W-1:0]  s_second_index,
    input  wire logic [CELL_W-1:0] s_cell_number,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CELL_W-1:0]      m_value_out,
    output logic [ROWO_W-1:0]      m_row_out,
    output logic [COLO_W-1:0]      m_col_out,
    output logic [KIND_W-1:0]      m_result_kind
);

    localparam int MAXD = (ROWS > COLS) ? ROWS : COLS;
    localparam int CNT_W = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(MAXD - 1);
    localparam logic [TBL_W:0]   ROW_LIM  = (TBL_W + 1)'(ROWS);
    localparam logic [TBL_W:0]   COL_LIM  = (TBL_W + 1)'(COLS);
    localparam logic [32:0]      CELL_LIM = 33'(longint'(ROWS) * longint'(COLS));
    localparam logic [CELL_W-1:0] COLS_V  = CELL_W'(COLS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    req_t              req_reg, req_next;
    logic [TBL_W-1:0]  idx_a_reg, idx_a_next;
    logic [TBL_W-1:0]  idx_b_reg, idx_b_next;
    logic [TBL_W-1:0]  p_reg, p_next;
    logic [TBL_W-1:0]  q_reg, q_next;
    logic [CELL_W-1:0] mul_reg, mul_next;
    logic [CELL_W-1:0] cv_reg, cv_next;

    logic [CELL_W-1:0] res_value_reg, res_value_next;
    logic [ROWO_W-1:0] res_row_reg, res_row_next;
    logic [COLO_W-1:0] res_col_reg, res_col_next;
    kind_t             res_kind_reg, res_kind_next;

    logic              m_valid_reg, m_valid_next;
    logic [CELL_W-1:0] m_value_reg;
    logic [ROWO_W-1:0] m_row_reg;
    logic [COLO_W-1:0] m_col_reg;
    kind_t             m_kind_reg;

    logic              accept, req_err, load, rd_en, swap_row;
    logic [TBL_W:0]    x_ext, y_ext, clr_ext, inv_row1, inv_col1;
    logic [TBL_W-1:0]  clr_idx;
    tbl_cmd_t          row_cmd, col_cmd, sw_cmd;
    tbl_rsp_t          row_rsp, col_rsp, sw_rsp;
    logic              div_valid;
    logic [CELL_W-1:0] div_num, div_quo;
    logic [TBL_W:0]    div_rem;

    gprt_table #(.DEPTH(ROWS)) u_row_tbl (
        .aclk (aclk),
        .cmd  (row_cmd),
        .rsp  (row_rsp)
    );

    gprt_table #(.DEPTH(COLS)) u_col_tbl (
        .aclk (aclk),
        .cmd  (col_cmd),
        .rsp  (col_rsp)
    );

    assign div_num = s_cell_number - CELL_W'(1);

    gprt_cdiv #(.COLS(COLS)) u_cdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && (req_t'(s_req_type) == REQ_LOCATE)),
        .in_num    (div_num),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_rem   (div_rem)
    );

    assign accept = s_valid && s_ready;
    assign x_ext  = (TBL_W + 1)'(s_first_index);
    assign y_ext  = (TBL_W + 1)'(s_second_index);

    // range checks on the incoming word
    always_comb begin
        case (req_t'(s_req_type))
            REQ_SWAP_ROW: req_err = (s_first_index == '0) || (x_ext > ROW_LIM) ||
                                    (s_second_index == '0) || (y_ext > ROW_LIM);
            REQ_SWAP_COL: req_err = (s_first_index == '0) || (x_ext > COL_LIM) ||
                                    (s_second_index == '0) || (y_ext > COL_LIM);
            REQ_QUERY:    req_err = (s_first_index == '0) || (x_ext > ROW_LIM) ||
                                    (s_second_index == '0) || (y_ext > COL_LIM);
            REQ_LOCATE:   req_err = (s_cell_number == '0) ||
                                    ({10'd0, s_cell_number} > CELL_LIM);
            default:      req_err = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == CLR_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (req_err) begin
                        state_next = ST_RESULT;
                    end else begin
                        case (req_t'(s_req_type))
                            REQ_SWAP_ROW, REQ_SWAP_COL: state_next = ST_SWAP_RD;
                            REQ_QUERY:                  state_next = ST_QRY_RD;
                            default:                    state_next = ST_LOC_DIV;
                        endcase
                    end
                end
            end
            ST_SWAP_RD:  state_next = ST_SWAP_WR1;
            ST_SWAP_WR1: state_next = ST_SWAP_WR2;
            ST_SWAP_WR2: state_next = ST_IDLE;
            ST_QRY_RD:   state_next = ST_QRY_MUL;
            ST_QRY_MUL:  state_next = ST_QRY_SUM;
            ST_QRY_SUM:  state_next = ST_RESULT;
            ST_LOC_DIV: begin
                if (div_valid) state_next = ST_LOC_RD;
            end
            ST_LOC_RD:   state_next = ST_LOC_GET;
            ST_LOC_GET:  state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default:     state_next = ST_CLEAR;
        endcase
    end

    assign swap_row = (req_reg == REQ_SWAP_ROW);
    assign sw_rsp   = swap_row ? row_rsp : col_rsp;
    assign clr_idx  = TBL_W'(clr_cnt_reg);
    assign clr_ext  = {1'b0, clr_idx};

    // control outputs and table commands
    always_comb begin
        s_ready = 1'b0;
        load    = 1'b0;
        rd_en   = 1'b0;
        sw_cmd  = '0;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_SWAP_RD, ST_QRY_RD, ST_LOC_RD: rd_en = 1'b1;
            // fwd[a] <= old fwd[b], inv[old fwd[b]] <= a
            ST_SWAP_WR1: begin
                sw_cmd.fwd_we    = 1'b1;
                sw_cmd.fwd_waddr = idx_a_reg;
                sw_cmd.fwd_wdata = sw_rsp.fwd_qb;
                sw_cmd.inv_we    = 1'b1;
                sw_cmd.inv_waddr = sw_rsp.fwd_qb;
                sw_cmd.inv_wdata = idx_a_reg;
            end
            ST_SWAP_WR2: begin
                sw_cmd.fwd_we    = 1'b1;
                sw_cmd.fwd_waddr = idx_b_reg;
                sw_cmd.fwd_wdata = sw_rsp.fwd_qa;
                sw_cmd.inv_we    = 1'b1;
                sw_cmd.inv_waddr = sw_rsp.fwd_qa;
                sw_cmd.inv_wdata = idx_b_reg;
            end
            ST_RESULT: load = !m_valid_reg || m_ready;
            default: ;
        endcase

        row_cmd = '0;
        col_cmd = '0;
        if (state_reg == ST_CLEAR) begin
            row_cmd.fwd_we    = clr_ext < ROW_LIM;
            row_cmd.inv_we    = clr_ext < ROW_LIM;
            col_cmd.fwd_we    = clr_ext < COL_LIM;
            col_cmd.inv_we    = clr_ext < COL_LIM;
            row_cmd.fwd_waddr = clr_idx;
            row_cmd.fwd_wdata = clr_idx;
            row_cmd.inv_waddr = clr_idx;
            row_cmd.inv_wdata = clr_idx;
            col_cmd.fwd_waddr = clr_idx;
            col_cmd.fwd_wdata = clr_idx;
            col_cmd.inv_waddr = clr_idx;
            col_cmd.inv_wdata = clr_idx;
        end else if (swap_row) begin
            row_cmd = sw_cmd;
        end else begin
            col_cmd = sw_cmd;
        end
        row_cmd.rd_en  = rd_en;
        row_cmd.rd_a   = idx_a_reg;
        row_cmd.rd_b   = idx_b_reg;
        row_cmd.rd_inv = p_reg;
        col_cmd.rd_en  = rd_en;
        col_cmd.rd_a   = idx_a_reg;
        col_cmd.rd_b   = idx_b_reg;
        col_cmd.rd_inv = q_reg;
    end

    assign inv_row1 = {1'b0, row_rsp.inv_q} + (TBL_W + 1)'(1);
    assign inv_col1 = {1'b0, col_rsp.inv_q} + (TBL_W + 1)'(1);

    // datapath next values
    always_comb begin
        clr_cnt_next   = clr_cnt_reg;
        req_next       = req_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        mul_next       = mul_reg;
        cv_next        = cv_reg;
        res_value_next = res_value_reg;
        res_row_next   = res_row_reg;
        res_col_next   = res_col_reg;
        res_kind_next  = res_kind_reg;

        if (state_reg == ST_CLEAR) clr_cnt_next = clr_cnt_reg + CNT_W'(1);

        if (accept) begin
            req_next       = req_t'(s_req_type);
            idx_a_next     = TBL_W'(s_first_index) - TBL_W'(1);
            idx_b_next     = TBL_W'(s_second_index) - TBL_W'(1);
            res_value_next = '0;
            res_row_next   = '0;
            res_col_next   = '0;
            res_kind_next  = KIND_ERR;
        end

        if (state_reg == ST_LOC_DIV && div_valid) begin
            p_next = div_quo[TBL_W-1:0];
            q_next = div_rem[TBL_W-1:0];
        end

        if (state_reg == ST_QRY_MUL) begin
            mul_next = CELL_W'(row_rsp.fwd_qa) * COLS_V;
            cv_next  = CELL_W'(col_rsp.fwd_qb);
        end

        if (state_reg == ST_QRY_SUM) begin
            res_value_next = mul_reg + cv_reg + CELL_W'(1);
            res_kind_next  = KIND_VALUE;
        end

        if (state_reg == ST_LOC_GET) begin
            res_row_next  = inv_row1[ROWO_W-1:0];
            res_col_next  = inv_col1[COLO_W-1:0];
            res_kind_next = KIND_POS;
        end
    end

    assign m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        idx_a_reg     <= idx_a_next;
        idx_b_reg     <= idx_b_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        mul_reg       <= mul_next;
        cv_reg        <= cv_next;
        res_value_reg <= res_value_next;
        res_row_reg   <= res_row_next;
        res_col_reg   <= res_col_next;
        res_kind_reg  <= res_kind_next;
        if (load) begin
            m_value_reg <= res_value_reg;
            m_row_reg   <= res_row_reg;
            m_col_reg   <= res_col_reg;
            m_kind_reg  <= res_kind_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value_out   = m_value_reg;
    assign m_row_out     = m_row_reg;
    assign m_col_out     = m_col_reg;
    assign m_result_kind = m_kind_reg;

    a_one_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |-> !(row_cmd.fwd_we && col_cmd.fwd_we))
        else $error("swap writes both axes at once");

    a_word_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("output word loaded outside result state");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_ERR) |->
            (m_value_reg == '0 && m_row_reg == '0 && m_col_reg == '0))
        else $error("error word carries nonzero fields");

    a_clr_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && clr_cnt_reg == CLR_LAST) |=> (state_reg == ST_IDLE))
        else $error("clearing pass did not end");

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for grid_permutation_remap_table: directed and random requests
// checked word by word against an in-bench copy of the four permutation tables.
// Depends on gprt_pkg and the RTL top grid_permutation_remap_table.
module tb_top;
    import gprt_pkg::*;

    localparam int ROWS         = 1024;
    localparam int COLS         = 4096;
    localparam int CELLS        = ROWS * COLS;
    localparam int ROW_TW       = $clog2(ROWS);
    localparam int COL_TW       = $clog2(COLS);
    localparam int IDX_MAX      = (1 << IDX_W) - 1;
    localparam int CELL_MAX     = (1 << CELL_W) - 1;
    localparam int RANDOM_ITEMS = 650;
    // the clearing pass after reset is the longest wait, everything else is short
    localparam int STALL_LIMIT  = 20000;

    typedef struct {
        req_t              kind;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  second;
        logic [CELL_W-1:0] cell_num;
        bit                drain;   // hold off until all answers are back
    } remap_req_t;

    typedef struct {
        logic [CELL_W-1:0] value;
        logic [ROWO_W-1:0] row;
        logic [COLO_W-1:0] col;
        kind_t             kind;
    } remap_answer_t;

    logic              aclk;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [TYPE_W-1:0] s_req_type     = '0;
    logic [IDX_W-1:0]  s_first_index  = '0;
    logic [IDX_W-1:0]  s_second_index = '0;
    logic [CELL_W-1:0] s_cell_number  = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [CELL_W-1:0] m_value_out;
    logic [ROWO_W-1:0] m_row_out;
    logic [COLO_W-1:0] m_col_out;
    logic [KIND_W-1:0] m_result_kind;

    grid_permutation_remap_table #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_first_index (s_first_index),
        .s_second_index(s_second_index),
        .s_cell_number (s_cell_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_out   (m_value_out),
        .m_row_out     (m_row_out),
        .m_col_out     (m_col_out),
        .m_result_kind (m_result_kind)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // model tables, 0-based entries
    logic [ROW_TW-1:0] row_fwd [ROWS];
    logic [ROW_TW-1:0] row_inv [ROWS];
    logic [COL_TW-1:0] col_fwd [COLS];
    logic [COL_TW-1:0] col_inv [COLS];

    remap_req_t    requests_todo[$];
    remap_answer_t answers_due[$];

    int  errors      = 0;
    int  idle_cycles = 0;
    int  mode_timer  = 0;
    int  s_gap       = 0;
    int  m_stall     = 0;
    bit  no_idle     = 1'b0;
    logic s_took     = 1'b0;
    logic m_took     = 1'b0;

    function automatic bit in_range(input logic [IDX_W-1:0] v, input int top);
        return (v >= 1) && (int'(v) <= top);
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 6));
    endfunction

    // update the tables for one accepted word and queue its answer, if any
    task automatic remap_apply(input req_t kind, input logic [IDX_W-1:0] a,
                               input logic [IDX_W-1:0] b,
                               input logic [CELL_W-1:0] cell_num);
        remap_answer_t ans;
        logic [ROW_TW-1:0] rva, rvb;
        logic [COL_TW-1:0] cva, cvb;
        int ia, ib, p, q;
        ans.value = '0;
        ans.row   = '0;
        ans.col   = '0;
        ans.kind  = KIND_ERR;
        ia = int'(a) - 1;
        ib = int'(b) - 1;
        case (kind)
            REQ_SWAP_ROW: begin
                if (in_range(a, ROWS) && in_range(b, ROWS)) begin
                    rva = row_fwd[ia];
                    rvb = row_fwd[ib];
                    row_fwd[ia] = rvb;
                    row_fwd[ib] = rva;
                    row_inv[rvb] = ROW_TW'(ia);
                    row_inv[rva] = ROW_TW'(ib);
                end else begin
                    answers_due.push_back(ans);
                end
            end
            REQ_SWAP_COL: begin
                if (in_range(a, COLS) && in_range(b, COLS)) begin
                    cva = col_fwd[ia];
                    cvb = col_fwd[ib];
                    col_fwd[ia] = cvb;
                    col_fwd[ib] = cva;
                    col_inv[cvb] = COL_TW'(ia);
                    col_inv[cva] = COL_TW'(ib);
                end else begin
                    answers_due.push_back(ans);
                end
            end
            REQ_QUERY: begin
                if (in_range(a, ROWS) && in_range(b, COLS)) begin
                    ans.value = CELL_W'(int'(row_fwd[ia]) * COLS + int'(col_fwd[ib]) + 1);
                    ans.kind  = KIND_VALUE;
                end
                answers_due.push_back(ans);
            end
            default: begin
                if (cell_num >= 1 && int'(cell_num) <= CELLS) begin
                    p = (int'(cell_num) - 1) / COLS;
                    q = (int'(cell_num) - 1) % COLS;
                    ans.row  = ROWO_W'(int'(row_inv[p]) + 1);
                    ans.col  = COLO_W'(int'(col_inv[q]) + 1);
                    ans.kind = KIND_POS;
                end
                answers_due.push_back(ans);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(negedge aclk) begin : req_drive
        remap_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (s_valid)
                s_gap = draw_gap();
            if (s_gap != 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (requests_todo.size() != 0 &&
                         !(requests_todo[0].drain && answers_due.size() != 0)) begin
                nxt = requests_todo.pop_front();
                s_valid        <= 1'b1;
                s_req_type     <= nxt.kind;
                s_first_index  <= nxt.first;
                s_second_index <= nxt.second;
                s_cell_number  <= nxt.cell_num;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_took)
                m_stall = draw_gap();
            if (m_stall != 0) begin
                m_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin : answer_mon
        remap_answer_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
            m_took <= 1'b0;
            idle_cycles = 0;
            for (int i = 0; i < ROWS; i++) begin
                row_fwd[i] = ROW_TW'(i);
                row_inv[i] = ROW_TW'(i);
            end
            for (int i = 0; i < COLS; i++) begin
                col_fwd[i] = COL_TW'(i);
                col_inv[i] = COL_TW'(i);
            end
        end else begin
            s_took <= s_valid && s_ready;
            m_took <= m_valid && m_ready;
            // results always belong to earlier words, so pop before predicting
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result word, result_kind %0d", m_result_kind);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("value_out", 32'(want.value), 32'(m_value_out));
                    check_field("row_out", 32'(want.row), 32'(m_row_out));
                    check_field("col_out", 32'(want.col), 32'(m_col_out));
                    check_field("result_kind", 32'(want.kind), 32'(m_result_kind));
                end
            end
            if (s_valid && s_ready)
                remap_apply(req_t'(s_req_type), s_first_index, s_second_index,
                            s_cell_number);
            mode_timer++;
            if (mode_timer % 128 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic add_req(input req_t kind, input int a, input int b, input int cell_num,
                           input bit drain);
        remap_req_t r;
        r.kind     = kind;
        r.first    = IDX_W'(a);
        r.second   = IDX_W'(b);
        r.cell_num = CELL_W'(cell_num);
        r.drain    = drain;
        requests_todo.push_back(r);
    endtask

    // in-range index, biased to a few low lines so swaps pile up on each other
    function automatic int pick_index(input int top);
        case ($urandom_range(0, 9))
            0:          return 1;
            1:          return top;
            2, 3, 4, 5: return $urandom_range(1, 8);
            default:    return $urandom_range(1, top);
        endcase
    endfunction

    function automatic int pick_cell();
        case ($urandom_range(0, 9))
            0:          return 1;
            1:          return CELLS;
            2, 3, 4, 5: return ($urandom_range(1, 8) - 1) * COLS + $urandom_range(1, 8);
            default:    return $urandom_range(1, CELLS);
        endcase
    endfunction

    function automatic int bad_index(input int top);
        return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(top + 1, IDX_MAX));
    endfunction

    initial begin : stimulus
        req_t k;
        int a, b, c, top_a, top_b;
        bit drain;

        // directed: extremes, self swaps, out-of-range cases of each request type
        add_req(REQ_SWAP_ROW, 1, ROWS, 0, 1'b0);
        add_req(REQ_SWAP_COL, 1, COLS, 0, 1'b0);
        add_req(REQ_QUERY, 1, 1, 0, 1'b0);
        add_req(REQ_QUERY, ROWS, COLS, 0, 1'b0);
        add_req(REQ_LOCATE, 0, 0, 1, 1'b0);
        add_req(REQ_LOCATE, 0, 0, CELLS, 1'b0);
        add_req(REQ_SWAP_ROW, 5, 5, 0, 1'b0);
        add_req(REQ_SWAP_COL, 7, 7, 0, 1'b0);
        add_req(REQ_QUERY, 5, 7, 0, 1'b0);
        add_req(REQ_SWAP_ROW, 0, 3, 0, 1'b0);
        add_req(REQ_SWAP_ROW, 3, ROWS + 1, 0, 1'b0);
        add_req(REQ_SWAP_COL, 0, 3, 0, 1'b0);
        add_req(REQ_SWAP_COL, 2, COLS + 1, 0, 1'b0);
        add_req(REQ_QUERY, 0, 1, 0, 1'b0);
        add_req(REQ_QUERY, ROWS + 1, 1, 0, 1'b0);
        add_req(REQ_QUERY, 1, COLS + 1, 0, 1'b0);
        add_req(REQ_QUERY, 1, 0, 0, 1'b0);
        add_req(REQ_LOCATE, 0, 0, 0, 1'b0);
        add_req(REQ_LOCATE, 0, 0, CELLS + 1, 1'b0);
        add_req(REQ_LOCATE, IDX_MAX, IDX_MAX, CELL_MAX, 1'b0);
        add_req(REQ_SWAP_ROW, IDX_MAX, IDX_MAX, CELL_MAX, 1'b0);
        add_req(REQ_QUERY, 2, 3, 0, 1'b1);
        add_req(REQ_LOCATE, 0, 0, 2 * COLS + 3, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            drain = ($urandom_range(0, 79) == 0);
            k = req_t'($urandom_range(0, 3));
            top_a = (k == REQ_SWAP_COL) ? COLS : ROWS;
            top_b = (k == REQ_SWAP_ROW) ? ROWS : COLS;
            case ($urandom_range(0, 19))
                0, 1: begin
                    // raw noise over every bit
                    add_req(k, $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                            $urandom_range(0, CELL_MAX), drain);
                end
                2, 3: begin
                    // one field out of range
                    a = pick_index(top_a);
                    b = pick_index(top_b);
                    c = ($urandom_range(0, 2) == 0) ? 0 :
                        int'($urandom_range(CELLS + 1, CELL_MAX));
                    if ($urandom_range(0, 1) == 0)
                        a = bad_index(top_a);
                    else
                        b = bad_index(top_b);
                    add_req(k, a, b, c, drain);
                end
                default: begin
                    if (k == REQ_LOCATE)
                        add_req(k, $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                                pick_cell(), drain);
                    else
                        add_req(k, pick_index(top_a), pick_index(top_b),
                                $urandom_range(0, CELL_MAX), drain);
                end
            endcase
        end

        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (requests_todo.size() != 0 || s_valid || answers_due.size() != 0)
            @(posedge aclk);
        // let a trailing swap finish and catch any stray result
        repeat (24) @(posedge aclk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
